FILE: rtl/load_store_byte_lane_unit_macros.svh
// ---------------------------------------------------------------------------
// load_store_byte_lane_unit_macros.svh
// Assertion shorthands for the load/store byte lane unit checkers.
// ---------------------------------------------------------------------------
`ifndef LOAD_STORE_BYTE_LANE_UNIT_MACROS_SVH
`define LOAD_STORE_BYTE_LANE_UNIT_MACROS_SVH

// Check a consequent in the same cycle as the antecedent
`define LSBLU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after the antecedent ends
`define LSBLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lsblu_pkg.sv
// ---------------------------------------------------------------------------
// lsblu_pkg
// Shared types, widths and operation codes of the load/store byte lane unit.
// ---------------------------------------------------------------------------
package lsblu_pkg;

  localparam int OP_W        = 3;
  localparam int ADDR_W      = 32;
  localparam int DATA_W      = 32;
  localparam int REG_W       = 5;
  localparam int STORE_WORDS = 1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PASS = 3'd0;
  localparam logic [OP_W-1:0] OP_LW   = 3'd1;
  localparam logic [OP_W-1:0] OP_LB   = 3'd2;
  localparam logic [OP_W-1:0] OP_LBU  = 3'd3;
  localparam logic [OP_W-1:0] OP_LHU  = 3'd4;
  localparam logic [OP_W-1:0] OP_SB   = 3'd5;
  localparam logic [OP_W-1:0] OP_SH   = 3'd6;
  localparam logic [OP_W-1:0] OP_SW   = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] store_data;
    logic [REG_W-1:0]  dest_reg;
  } lsblu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ADDR_W-1:0] alu_result;
    logic [REG_W-1:0]  dest_out;
  } lsblu_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take the request and read its word
    logic commit;   // merge, write back and load the response register
  } lsblu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free; // response register empty or being taken this cycle
  } lsblu_status_t;

endpackage

FILE: rtl/lsblu_ctrl.sv
// ---------------------------------------------------------------------------
// lsblu_ctrl
// Two-state sequencer: take a request and read its word, then commit it.
// ---------------------------------------------------------------------------
module lsblu_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  lsblu_pkg::lsblu_status_t status,
  output lsblu_pkg::lsblu_cmd_t    cmd
);
  import lsblu_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic state;
  logic state_next;

  // Accept only while idle
  assign req_ready   = (state == ST_IDLE);
  assign cmd.capture = req_valid && req_ready;
  assign cmd.commit  = (state == ST_MERGE) && status.out_free;

  // Advance on accept, return once the response register takes the result
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/lsblu_dpath.sv
// ---------------------------------------------------------------------------
// lsblu_dpath
// Request register, word store, lane extract/merge and response register.
// ---------------------------------------------------------------------------
module lsblu_dpath #(
  parameter int STORE_WORDS = lsblu_pkg::STORE_WORDS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lsblu_pkg::lsblu_req_t    req,
  input  lsblu_pkg::lsblu_cmd_t    cmd,
  output lsblu_pkg::lsblu_status_t status,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output lsblu_pkg::lsblu_rsp_t    rsp
);
  import lsblu_pkg::*;

  // Word index width; the store depth must be a power of two (not enforced here) so the index wraps
  localparam int IDX_W = $clog2(STORE_WORDS);

  logic [DATA_W-1:0] mem [STORE_WORDS];

  lsblu_req_t        item;
  logic [DATA_W-1:0] word_q;
  logic [1:0]        lane;
  logic              half;
  logic [7:0]        byte_sel;
  logic [15:0]       half_sel;
  logic [DATA_W-1:0] merged;
  logic [DATA_W-1:0] load_val;
  logic              is_store;

  // Hold the request and read its word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item   <= req;
      word_q <= mem[req.address[2 +: IDX_W]];
    end
  end

  // Lane selection from byte-address bits
  assign lane     = item.address[1:0];
  assign half     = item.address[1];
  assign byte_sel = word_q[{lane, 3'b000} +: 8];
  assign half_sel = word_q[{half, 4'b0000} +: 16];
  assign is_store = (item.op == OP_SB) || (item.op == OP_SH) || (item.op == OP_SW);

  // Extract load value and merge store data into the read word
  always_comb begin
    merged   = word_q;
    load_val = '0;
    unique case (item.op)
      OP_LW:   load_val = word_q;
      OP_LB:   load_val = {{(DATA_W-8){byte_sel[7]}}, byte_sel};
      OP_LBU:  load_val = {{(DATA_W-8){1'b0}}, byte_sel};
      OP_LHU:  load_val = {{(DATA_W-16){1'b0}}, half_sel};
      OP_SB:   merged[{lane, 3'b000} +: 8]  = item.store_data[7:0];
      OP_SH:   merged[{half, 4'b0000} +: 16] = item.store_data[15:0];
      OP_SW:   merged = item.store_data;
      default: ;
    endcase
  end

  // Write back the merged word
  always_ff @(posedge clk) begin
    if (cmd.commit && is_store) begin
      mem[item.address[2 +: IDX_W]] <= merged;
    end
  end

  assign status.out_free = !rsp_valid || rsp_ready;

  // Response register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.read_data  <= load_val;
      rsp.alu_result <= item.address;
      rsp.dest_out   <= item.dest_reg;
    end
  end

endmodule

FILE: rtl/load_store_byte_lane_unit.sv
// ---------------------------------------------------------------------------
// load_store_byte_lane_unit
// Memory stage: word/byte/halfword loads and read-modify-write stores.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries op, byte address, store
//   data and destination register. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns read data, the address as ALU result and the destination.
//   One response per request, in order.
// Sequencing:
//   A request is taken in the idle state; its word is read from the store
//   at that edge. In the merge state, once the response register is free,
//   the lane is extracted or merged, a store writes back and the response
//   register loads. The single-port read then write of the word store
//   keep one request in flight; the next is taken after the last commits.
// Reset:
//   Clears the sequencer and the response valid. The store holds no reset
//   value; words read before being written return unknown data.
// Stall:
//   A waiting response holds stable; the next request is taken and its
//   word read, then it waits until the response register frees up.
// STORE_WORDS must be a power of two; higher word-index bits wrap.
// ---------------------------------------------------------------------------
module load_store_byte_lane_unit #(
  parameter int STORE_WORDS = lsblu_pkg::STORE_WORDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  lsblu_pkg::lsblu_req_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output lsblu_pkg::lsblu_rsp_t rsp
);
  import lsblu_pkg::*;

  lsblu_cmd_t    cmd;
  lsblu_status_t status;

  lsblu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lsblu_dpath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/lsblu_checker.sv
// ---------------------------------------------------------------------------
// lsblu_checker
// Port-level checks of the load/store byte lane unit, bound to the top.
// ---------------------------------------------------------------------------
`include "load_store_byte_lane_unit_macros.svh"

module lsblu_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input lsblu_pkg::lsblu_req_t req,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input lsblu_pkg::lsblu_rsp_t rsp
);
  import lsblu_pkg::*;

  // Stalled response holds
  `LSBLU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

  // No response valid right after reset
  `LSBLU_ASSERT_SAME(a_rst_empty, $past(rst), !rsp_valid, "response valid after reset")

  // One request in flight: not ready in the cycle after accept
  `LSBLU_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready, "ready right after accept")

  // With a free response register the request's response follows
  `LSBLU_ASSERT_NEXT(a_rsp_pass, req_valid && req_ready ##1 (!rsp_valid || rsp_ready), rsp_valid && rsp.alu_result == $past(req.address, 2) && rsp.dest_out == $past(req.dest_reg, 2), "response fields do not match request")

  // Stores and passes return zero read data
  `LSBLU_ASSERT_NEXT(a_rsp_zero, req_valid && req_ready && (req.op == OP_PASS || req.op == OP_SB || req.op == OP_SH || req.op == OP_SW) ##1 (!rsp_valid || rsp_ready), rsp.read_data == '0, "nonzero read data for store or pass")

endmodule

bind load_store_byte_lane_unit lsblu_checker u_lsblu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: test/load_store_byte_lane_unit_tb.sv
// ---------------------------------------------------------------------------
// load_store_byte_lane_unit_tb
// Self-checking bench for the memory stage. A short table of directed
// requests covers every operation, the address extremes, lane selection,
// ignored low bits and index wrap. Random requests follow, aimed at a
// small set of hot words. Each response is compared field by field with
// a behavioral predictor that keeps its own copy of the word store. Both
// channels idle in random bursts, and the response side holds off once
// for a long stretch. No word is read before it has been written.
// ---------------------------------------------------------------------------
module load_store_byte_lane_unit_tb;
  import lsblu_pkg::*;

  localparam int IDX_W        = $clog2(STORE_WORDS);
  localparam int RANDOM_ITEMS = 1750;
  localparam int TAIL_ITEMS   = 150;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    lsblu_req_t        item;
    bit                typed;
    logic [DATA_W-1:0] read_data;
  } stim_row_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  lsblu_req_t req       = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  lsblu_rsp_t rsp;

  // Mirror of the word store and which words hold defined data
  logic [DATA_W-1:0] data_mem_mirror [STORE_WORDS];
  bit                word_written [STORE_WORDS];

  lsblu_rsp_t  writeback_q [$];
  stim_row_t   directed_rows [$];
  int unsigned hot_words [8];

  int  error_count    = 0;
  int  accepted_count = 0;
  int  checked_count  = 0;
  int  load_count     = 0;
  int  store_count    = 0;
  int  pass_count     = 0;
  int  cycle_count    = 0;
  bit  tail_phase     = 1'b0;
  bit  hold_done      = 1'b0;
  lsblu_rsp_t exp_rsp;

  load_store_byte_lane_unit #(
    .STORE_WORDS(STORE_WORDS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("** load_store_byte_lane_unit: FAILED **");
      $finish;
    end
  end

  // Compute the writeback of one request and update the store mirror
  function automatic lsblu_rsp_t predict_writeback(lsblu_req_t r);
    int unsigned       idx;
    int unsigned       bsel;
    int unsigned       hsel;
    logic [DATA_W-1:0] word;
    logic [7:0]        lane_b;
    logic [15:0]       lane_h;
    lsblu_rsp_t        res;
    idx    = 32'(r.address[IDX_W+1:2]);
    bsel   = 8 * int'(r.address[1:0]);
    hsel   = 16 * int'(r.address[1]);
    word   = data_mem_mirror[idx];
    lane_b = word[bsel +: 8];
    lane_h = word[hsel +: 16];
    res.read_data  = '0;
    res.alu_result = r.address;
    res.dest_out   = r.dest_reg;
    case (r.op)
      OP_LW:  res.read_data = word;
      OP_LB:  res.read_data = {{24{lane_b[7]}}, lane_b};
      OP_LBU: res.read_data = {24'h0, lane_b};
      OP_LHU: res.read_data = {16'h0, lane_h};
      OP_SB: begin
        word[bsel +: 8] = r.store_data[7:0];
        data_mem_mirror[idx] = word;
      end
      OP_SH: begin
        word[hsel +: 16] = r.store_data[15:0];
        data_mem_mirror[idx] = word;
      end
      OP_SW: begin
        data_mem_mirror[idx] = r.store_data;
        word_written[idx] = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random request, mostly to hot words; never reads an unwritten word
  function automatic lsblu_req_t random_request();
    lsblu_req_t  r;
    int unsigned idx;
    if ($urandom_range(0, 3) != 0) idx = hot_words[$urandom_range(0, 7)];
    else idx = $urandom_range(0, STORE_WORDS - 1);
    r.op         = OP_W'($urandom_range(0, 7));
    r.address    = $urandom();
    r.address[IDX_W+1:2] = idx[IDX_W-1:0];
    r.store_data = $urandom();
    r.dest_reg   = REG_W'($urandom_range(0, 31));
    if (!word_written[idx] && r.op != OP_PASS && r.op != OP_SW) r.op = OP_SW;
    return r;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                         logic [DATA_W-1:0] data, logic [REG_W-1:0] dest,
                         bit typed, logic [DATA_W-1:0] rd);
    stim_row_t row;
    row.item.op         = op;
    row.item.address    = addr;
    row.item.store_data = data;
    row.item.dest_reg   = dest;
    row.typed           = typed;
    row.read_data       = rd;
    directed_rows.push_back(row);
  endtask

  // Offer one request until taken, then queue its expected writeback
  task automatic send_request(lsblu_req_t item, bit typed, logic [DATA_W-1:0] typed_rd);
    lsblu_rsp_t pred;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pred = predict_writeback(item);
    if (typed) pred.read_data = typed_rd;
    writeback_q.push_back(pred);
    accepted_count++;
    case (item.op)
      OP_PASS:             pass_count++;
      OP_SB, OP_SH, OP_SW: store_count++;
      default:             load_count++;
    endcase
  endtask

  // Drop the request valid for a random burst
  task automatic request_gap();
    if (!tail_phase && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, expv, actv);
    end
  endtask

  // Compare each taken response with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (writeback_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: response with none expected, expected none actual %h",
                   $time, rsp);
      end else begin
        exp_rsp = writeback_q.pop_front();
        checked_count++;
        check_field("read_data", exp_rsp.read_data, rsp.read_data);
        check_field("alu_result", exp_rsp.alu_result, rsp.alu_result);
        check_field("dest_out", 32'(exp_rsp.dest_out), 32'(rsp.dest_out));
      end
    end
  end

  // Response side: random stalls, one long hold, none in the tail
  initial begin
    repeat (6) @(posedge clk);
    forever begin
      if (!hold_done && accepted_count >= HOLD_AT) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Request side: directed table, then random requests
  initial begin
    // store word 0 and the top word, then read lanes back
    add_row(OP_SW,   32'h0000_0000, 32'hFFFF_FFFF, 5'd0,  1, 32'h0000_0000);
    add_row(OP_LW,   32'h0000_0000, 32'h0000_0000, 5'd31, 1, 32'hFFFF_FFFF);
    add_row(OP_SW,   32'hFFFF_FFFF, 32'h8040_2010, 5'd31, 1, 32'h0000_0000);
    add_row(OP_LW,   32'h0000_0FFC, 32'hFFFF_FFFF, 5'd1,  1, 32'h8040_2010);
    add_row(OP_LB,   32'h0000_0FFF, 32'h0000_0000, 5'd2,  1, 32'hFFFF_FF80);
    add_row(OP_LBU,  32'h0000_0FFF, 32'h0000_0000, 5'd3,  1, 32'h0000_0080);
    add_row(OP_LB,   32'h0000_0FFC, 32'h0000_0000, 5'd4,  1, 32'h0000_0010);
    add_row(OP_LB,   32'h0000_0FFE, 32'h0000_0000, 5'd5,  1, 32'h0000_0040);
    add_row(OP_LHU,  32'h0000_0FFE, 32'h0000_0000, 5'd6,  1, 32'h0000_8040);
    // bit 0 ignored for halfwords
    add_row(OP_LHU,  32'h0000_0FFD, 32'h0000_0000, 5'd7,  1, 32'h0000_2010);
    // byte merge, then read back through a wrapped address
    add_row(OP_SB,   32'h0000_0001, 32'h1234_56AB, 5'd8,  1, 32'h0000_0000);
    add_row(OP_LW,   32'h0000_1000, 32'h0000_0000, 5'd9,  1, 32'hFFFF_ABFF);
    add_row(OP_SH,   32'h0000_0003, 32'hDEAD_0000, 5'd10, 1, 32'h0000_0000);
    add_row(OP_LW,   32'h0000_0000, 32'h0000_0000, 5'd11, 1, 32'h0000_ABFF);
    add_row(OP_SH,   32'h0000_0000, 32'h0000_BEEF, 5'd12, 1, 32'h0000_0000);
    add_row(OP_LHU,  32'h0000_0002, 32'h0000_0000, 5'd13, 1, 32'h0000_0000);
    add_row(OP_LHU,  32'h0000_0001, 32'h0000_0000, 5'd14, 1, 32'h0000_BEEF);
    // pass-through at both extremes
    add_row(OP_PASS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1, 32'h0000_0000);
    add_row(OP_PASS, 32'h0000_0000, 32'h0000_0000, 5'd0,  1, 32'h0000_0000);
    add_row(OP_SB,   32'h0000_0FFE, 32'h0000_00FF, 5'd15, 1, 32'h0000_0000);
    add_row(OP_LB,   32'hFFFF_FFFE, 32'h0000_0000, 5'd16, 0, 32'h0000_0000);
    add_row(OP_LBU,  32'h0000_0FFD, 32'h0000_0000, 5'd17, 0, 32'h0000_0000);
    add_row(OP_SW,   32'h0000_0004, 32'h0000_0000, 5'd18, 1, 32'h0000_0000);
    add_row(OP_LW,   32'h8000_0004, 32'hFFFF_FFFF, 5'd19, 1, 32'h0000_0000);

    foreach (hot_words[i]) hot_words[i] = $urandom_range(0, STORE_WORDS - 1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      request_gap();
      send_request(directed_rows[i].item, directed_rows[i].typed,
                   directed_rows[i].read_data);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      tail_phase = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      request_gap();
      send_request(random_request(), 1'b0, '0);
    end

    // Drain outstanding responses
    req_valid <= 1'b0;
    while (writeback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses: %0d loads, %0d stores, %0d pass-through (%0d directed).",
             checked_count, load_count, store_count, pass_count, directed_rows.size());
    $display("Random idling on both channels, one %0d-cycle response hold-off, %0d errors.",
             HOLD_CYCLES, error_count);
    if (error_count == 0) begin
      $display("** load_store_byte_lane_unit: PASSED **");
    end else begin
      $display("** load_store_byte_lane_unit: FAILED **");
    end
    $finish;
  end

endmodule
